// ----- design/pcqsg_pkg.sv -----
// Shared types, widths and codes for the per-cluster queue steal gate.
`timescale 1ns / 1ps

package pcqsg_pkg;

  localparam int NUM_CLUSTERS = 16;
  localparam int MAX_DEPTH    = 65535;

  localparam int IDX_W      = $clog2(NUM_CLUSTERS);
  localparam int CNT_W      = $clog2(NUM_CLUSTERS + 1);
  localparam int DEPTH_W    = 16;
  localparam int TIME_W     = 64;
  localparam int MIN_W      = 16;
  localparam int DELAY_W    = 32;
  localparam int ACT_W      = 5;
  localparam int CLU_W      = 4;
  localparam int STAT_W     = 3;
  localparam int SRC_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [TIME_W-1:0]  time_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEAL_MIN   = 2'd0,
    REG_STEAL_DELAY = 2'd1,
    REG_ACTIVE      = 2'd2
  } reg_idx_t;

  typedef enum logic {
    REQ_ENQ  = 1'b0,
    REQ_DISP = 1'b1
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ENQ   = 3'd0,
    ST_FULL  = 3'd1,
    ST_LOCAL = 3'd2,
    ST_STEAL = 3'd3,
    ST_NONE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    C_NOP       = 2'd0,
    C_INC       = 2'd1,
    C_INC_STAMP = 2'd2,
    C_TAKE      = 2'd3
  } cell_op_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    cell_op_t             op;
    idx_t                 tgt;
    idx_t                 req;
    idx_t                 last;
    time_t                now;
    logic [MIN_W-1:0]     min_depth;
    logic [DELAY_W-1:0]   delay;
  } bcast_t;

  typedef struct packed {
    logic hit;
    logic stop;
  } cell_stat_t;

endpackage

// ----- design/pcqsg_cell.sv -----
// One queue cell: depth counter, head timestamp and one stage of the steal token chain.
`timescale 1ns / 1ps

module pcqsg_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcqsg_pkg::idx_t       cell_idx,
  input  pcqsg_pkg::bcast_t     bc,
  input  logic                  tok_in,
  output logic                  tok_out,
  output pcqsg_pkg::cell_stat_t stat,
  output pcqsg_pkg::depth_t     depth
);
  import pcqsg_pkg::*;

  depth_t depth_r, depth_nxt;
  time_t  head_r, head_nxt;
  logic   tok_r;
  logic   mine, eligible, hit, is_last;

  always_comb begin
    mine     = (bc.tgt == cell_idx);
    eligible = (depth_r > bc.min_depth) &&
               ((bc.now - head_r) > TIME_W'(bc.delay));
    hit      = tok_r && (cell_idx != bc.req) && eligible;
    is_last  = (cell_idx == bc.last);
    tok_out   = tok_r && !hit && !is_last;
    stat.hit  = hit;
    stat.stop = tok_r && !hit && is_last;
    depth     = depth_r;
  end

  always_comb begin
    depth_nxt = depth_r;
    head_nxt  = head_r;
    case (bc.op)
      C_INC: begin
        if (mine) depth_nxt = depth_r + 1'b1;
      end
      C_INC_STAMP: begin
        if (mine) begin
          depth_nxt = depth_r + 1'b1;
          head_nxt  = bc.now;
        end
      end
      C_TAKE: begin
        if (mine) begin
          depth_nxt = depth_r - 1'b1;
          head_nxt  = bc.now;
        end
      end
      default: begin
        if (hit) begin
          depth_nxt = depth_r - 1'b1;
          head_nxt  = bc.now;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      head_r  <= '0;
      tok_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      head_r  <= head_nxt;
      tok_r   <= tok_in;
    end
  end

endmodule

// ----- design/per_cluster_queue_steal_gate_unit.sv -----
// Top level of the per-cluster queue steal gate: controller, config registers and the cell row.
//
//   Channel  Direction  Handshake            Word contents
//   in_      input      in_valid/in_ready    req_type, cluster, now_ns
//   out_     output     out_valid/out_ready  status, source_cluster
//   cfg_     input      cfg_we (no wait)     cfg_idx, cfg_wdata
//
// An enqueue or a local take: the word is accepted, then, once the output register is free, the
// addressed cell updates and the result is registered. A dispatch that finds its own queue
// empty hands a token along the row of cells, one cell per cycle, until it stops at a cell
// that can be robbed or at the last active cell, and the result is then registered.
// Reset is synchronous and clears every depth and head time; the configuration registers
// return to their default values.
// A word may be accepted while the previous result still waits; its processing then stalls
// until the output register is free, so nothing is changed twice.
`timescale 1ns / 1ps

module per_cluster_queue_steal_gate_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [pcqsg_pkg::CLU_W-1:0]      in_cluster,
  input  logic [pcqsg_pkg::TIME_W-1:0]     in_now_ns,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pcqsg_pkg::STAT_W-1:0]     out_status,
  output logic [pcqsg_pkg::SRC_W-1:0]      out_source_cluster,
  input  logic                             cfg_we,
  input  logic [pcqsg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pcqsg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pcqsg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [MIN_W-1:0]   cfg_min_r;
  logic [DELAY_W-1:0] cfg_delay_r;
  logic [ACT_W-1:0]   cfg_active_r;

  // The word being worked on.
  req_t  type_r, type_nxt;
  idx_t  clu_r, clu_nxt;
  time_t now_r, now_nxt;

  // Output register.
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  idx_t    out_src_r, out_src_nxt;

  cnt_t       act_n;
  idx_t       last_idx;
  bcast_t     bc;
  cell_op_t   op;
  logic       start_scan;
  logic       slot_free;
  logic       load;
  logic       any_hit, any_stop;
  idx_t       hit_idx;
  depth_t     own_depth;

  logic       tok_in  [NUM_CLUSTERS];
  logic       tok_out [NUM_CLUSTERS];
  cell_stat_t stat    [NUM_CLUSTERS];
  depth_t     depth   [NUM_CLUSTERS];

  // A zero active count behaves as one, and anything beyond the row as the whole row.
  always_comb begin
    if (cfg_active_r == '0) begin
      act_n = CNT_W'(1);
    end else if (int'(cfg_active_r) > NUM_CLUSTERS) begin
      act_n = CNT_W'(NUM_CLUSTERS);
    end else begin
      act_n = CNT_W'(cfg_active_r);
    end
    last_idx = IDX_W'(act_n - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_min_r    <= MIN_W'(2);
      cfg_delay_r  <= DELAY_W'(500000);
      cfg_active_r <= ACT_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_STEAL_MIN:   cfg_min_r    <= cfg_wdata[MIN_W-1:0];
        REG_STEAL_DELAY: cfg_delay_r  <= cfg_wdata[DELAY_W-1:0];
        REG_ACTIVE:      cfg_active_r <= cfg_wdata[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign own_depth = depth[clu_r];

  // Stolen-from cell: only one token is ever in the row, so at most one hit.
  always_comb begin
    any_hit  = 1'b0;
    any_stop = 1'b0;
    hit_idx  = '0;
    for (int i = 0; i < NUM_CLUSTERS; i++) begin
      any_hit  = any_hit | stat[i].hit;
      any_stop = any_stop | stat[i].stop;
      if (stat[i].hit) hit_idx = IDX_W'(i);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    type_nxt       = type_r;
    clu_nxt        = clu_r;
    now_nxt        = now_r;
    op             = C_NOP;
    start_scan     = 1'b0;
    load           = 1'b0;
    out_status_nxt = out_status_r;
    out_src_nxt    = out_src_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          type_nxt = req_t'(in_req_type);
          now_nxt  = in_now_ns;
          // Clusters outside the active range fold onto cluster zero.
          if (int'(in_cluster) < int'(act_n)) begin
            clu_nxt = IDX_W'(in_cluster);
          end else begin
            clu_nxt = '0;
          end
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          out_src_nxt = clu_r;
          if (type_r == REQ_ENQ) begin
            load      = 1'b1;
            state_nxt = S_IDLE;
            if (int'(own_depth) >= MAX_DEPTH) begin
              out_status_nxt = ST_FULL;
            end else begin
              out_status_nxt = ST_ENQ;
              op = (own_depth == '0) ? C_INC_STAMP : C_INC;
            end
          end else if (own_depth != '0) begin
            load           = 1'b1;
            op             = C_TAKE;
            out_status_nxt = ST_LOCAL;
            state_nxt      = S_IDLE;
          end else begin
            start_scan = 1'b1;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // The output register was free on entry and nothing else fills it meanwhile.
        if (any_hit) begin
          load           = 1'b1;
          out_status_nxt = ST_STEAL;
          out_src_nxt    = hit_idx;
          state_nxt      = S_IDLE;
        end else if (any_stop) begin
          load           = 1'b1;
          out_status_nxt = ST_NONE;
          out_src_nxt    = clu_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r       <= type_nxt;
    clu_r        <= clu_nxt;
    now_r        <= now_nxt;
    out_status_r <= out_status_nxt;
    out_src_r    <= out_src_nxt;
  end

  always_comb begin
    bc.op        = op;
    bc.tgt       = clu_r;
    bc.req       = clu_r;
    bc.last      = last_idx;
    bc.now       = now_r;
    bc.min_depth = cfg_min_r;
    bc.delay     = cfg_delay_r;
  end

  // The row of cells; the token enters at cell zero and walks upwards.
  for (genvar g = 0; g < NUM_CLUSTERS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign tok_in[g] = start_scan;
    end else begin : g_link
      assign tok_in[g] = tok_out[g-1];
    end

    pcqsg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .bc       (bc),
      .tok_in   (tok_in[g]),
      .tok_out  (tok_out[g]),
      .stat     (stat[g]),
      .depth    (depth[g])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_source_cluster = SRC_W'(out_src_r);

endmodule

// ----- design/pcqsg_checker.sv -----
// Port-level checker for the per-cluster queue steal gate, bound to the top level.
`timescale 1ns / 1ps

module pcqsg_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_req_type,
  input logic [pcqsg_pkg::CLU_W-1:0]      in_cluster,
  input logic [pcqsg_pkg::TIME_W-1:0]     in_now_ns,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [pcqsg_pkg::STAT_W-1:0]     out_status,
  input logic [pcqsg_pkg::SRC_W-1:0]      out_source_cluster,
  input logic                             cfg_we,
  input logic [pcqsg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input logic [pcqsg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pcqsg_pkg::*;

  // A held result keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_source_cluster))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_ENQ || out_status == ST_FULL ||
      out_status == ST_LOCAL || out_status == ST_STEAL || out_status == ST_NONE))
    else $error("unknown status code");

  // One word at a time: an accepted word closes the input until it is done.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in flight");

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind per_cluster_queue_steal_gate_unit pcqsg_checker u_pcqsg_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the per-cluster queue steal gate unit.
`timescale 1ns / 1ps

module tb_top;
  import pcqsg_pkg::*;

  // The spare register index decodes to nothing and must leave the
  // configuration untouched.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // One expected result word.
  typedef struct {
    status_t              status;
    logic [SRC_W-1:0]     src;
  } result_t;

  // Patterns for the receiving side's stalls.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PATTERN,
    RX_HOLD
  } rx_mode_t;

  // Every input of the unit has a known value from time zero.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = 1'b0;
  logic [CLU_W-1:0]      in_cluster = '0;
  logic [TIME_W-1:0]     in_now_ns = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STAT_W-1:0]     out_status;
  logic [SRC_W-1:0]      out_source_cluster;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Our own copy of the queue state and of the configuration registers,
  // starting from their reset values.
  depth_t                q_depth [NUM_CLUSTERS];
  time_t                 q_head [NUM_CLUSTERS];
  logic [MIN_W-1:0]      min_depth_r = 16'd2;
  logic [DELAY_W-1:0]    delay_r = 32'd500000;
  logic [ACT_W-1:0]      active_r = 5'd1;

  // Results still owed by the unit, oldest first.
  result_t               expected_words [$];
  int                    errors = 0;

  // Sender burst state, receiver stall state, and the running time base.
  int unsigned           burst_left = 0;
  bit                    rush = 1'b0;
  rx_mode_t              rx_mode = RX_OPEN;
  int unsigned           rx_left = 0;
  logic [10:0]           rx_pattern = 11'b10110011101;
  time_t                 clock_ns = 64'h0000_0040_0000_0000;

  initial begin
    for (int i = 0; i < NUM_CLUSTERS; i++) begin
      q_depth[i] = '0;
      q_head[i] = '0;
    end
  end

  per_cluster_queue_steal_gate_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_cluster         (in_cluster),
    .in_now_ns          (in_now_ns),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_source_cluster (out_source_cluster),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Applies one accepted word to our copy of the queues and records the
  // result that the unit owes for it. The effective active count clamps 0
  // up to one cluster and anything above the row size down to the row size;
  // a cluster index at or beyond it falls back to cluster 0.
  function automatic void advance_queues(req_t kind, logic [CLU_W-1:0] cl, time_t now);
    int      n;
    int      c;
    int      i;
    time_t   waited;
    result_t r;
    n = (active_r == 0) ? 1 : (active_r > NUM_CLUSTERS) ? NUM_CLUSTERS : int'(active_r);
    c = (int'(cl) < n) ? int'(cl) : 0;
    r.src = c[SRC_W-1:0];
    if (kind == REQ_ENQ) begin
      if (q_depth[c] == MAX_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // Only the first task into an empty queue sets its head time.
        if (q_depth[c] == 0) q_head[c] = now;
        q_depth[c] = q_depth[c] + 1'b1;
        r.status = ST_ENQ;
      end
    end else if (q_depth[c] != 0) begin
      q_depth[c] = q_depth[c] - 1'b1;
      q_head[c] = now;
      r.status = ST_LOCAL;
    end else begin
      // Own queue empty: the first other cluster, in rising index order,
      // that is both deep enough and has waited long enough is robbed. The
      // wait is an unsigned difference, so it wraps with the time base.
      r.status = ST_NONE;
      for (i = 0; i < n; i++) begin
        waited = now - q_head[i];
        if (i != c && r.status == ST_NONE && q_depth[i] > min_depth_r &&
            waited > {32'd0, delay_r}) begin
          q_depth[i] = q_depth[i] - 1'b1;
          q_head[i] = now;
          r.status = ST_STEAL;
          r.src = i[SRC_W-1:0];
        end
      end
    end
    expected_words.push_back(r);
  endfunction

  // Offers one word and waits until the unit takes it. The sender works in
  // bursts; between bursts it may drop valid for a random gap. Valid stays high
  // after acceptance so that back-to-back words keep it raised, and only one
  // nonblocking assignment lands on it per falling edge.
  task automatic send_word(input req_t kind, input logic [CLU_W-1:0] cl, input time_t now);
    int unsigned gap;
    @(negedge clk);
    if (!rush && burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_cluster  <= cl;
    in_now_ns   <= now;
    do @(posedge clk); while (!in_ready);
    advance_queues(kind, cl, now);
  endtask

  // Stops offering words and waits until every owed result has come back,
  // then waits on so that the unit is fully idle.
  task automatic wait_for_drain;
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one configuration register while the unit is idle and mirrors the
  // write in our copy, with the same truncation to the register's width.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_for_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_STEAL_MIN:   min_depth_r = data[MIN_W-1:0];
      REG_STEAL_DELAY: delay_r = data;
      REG_ACTIVE:      active_r = data[ACT_W-1:0];
      default: ;
    endcase
  endtask

  // Sets all three registers. Bits above a register's width carry junk so
  // that the unit is seen to ignore them.
  task automatic set_config(input logic [MIN_W-1:0] mn, input logic [DELAY_W-1:0] dl,
                            input logic [ACT_W-1:0] act);
    write_reg(REG_STEAL_MIN, {16'($urandom), mn});
    write_reg(REG_STEAL_DELAY, dl);
    write_reg(REG_ACTIVE, {27'($urandom), act});
  endtask

  // Receiver: out_ready follows a stall pattern that is picked anew at random
  // intervals, from always ready through coin tosses and a fixed rotating
  // pattern to long holds. During the queue fill it simply stays ready.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(4, 40);
    end
    rx_left--;
    rx_pattern = {rx_pattern[9:0], rx_pattern[10]};
    if (rush) begin
      out_ready <= 1'b1;
    end else begin
      case (rx_mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_COIN:    out_ready <= $urandom_range(0, 1);
        RX_PATTERN: out_ready <= rx_pattern[0];
        default:    out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Every accepted result word is held against the oldest expectation.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, status %0d source %0d",
                 $time, out_status, out_source_cluster);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_source_cluster !== want.src) begin
          $display("%0t: source cluster expected %0d actual %0d",
                   $time, want.src, out_source_cluster);
          errors++;
        end
      end
    end
  end

  // With the reset configuration only cluster 0 is in use: every index maps
  // onto it and there is nobody to steal from. The time fields take both
  // extremes here.
  task automatic test_reset_defaults;
    send_word(REQ_ENQ, 4'd0, 64'd0);
    send_word(REQ_ENQ, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(REQ_DISP, 4'd9, 64'd10);
    send_word(REQ_DISP, 4'd0, 64'd11);
    send_word(REQ_DISP, 4'd0, 64'd12);
  endtask

  // The two steal gates at their edges: a wait equal to the delay is not
  // enough, one nanosecond more is; a depth equal to the minimum is not
  // enough. Also an out-of-range index on four active clusters, and a head
  // time stamped just before the time base wraps.
  task automatic test_steal_rules;
    time_t t0;
    t0 = 64'h0000_1234_0000_0000;
    set_config(16'd2, 32'd100, 5'd4);
    send_word(REQ_ENQ, 4'd2, t0);
    send_word(REQ_ENQ, 4'd2, t0 + 5);
    send_word(REQ_ENQ, 4'd2, t0 + 7);
    send_word(REQ_DISP, 4'd0, t0 + 100);
    send_word(REQ_DISP, 4'd1, t0 + 101);
    send_word(REQ_DISP, 4'd3, t0 + 500);
    send_word(REQ_ENQ, 4'd9, t0 + 510);
    send_word(REQ_DISP, 4'd0, t0 + 520);
    send_word(REQ_ENQ, 4'd1, 64'hFFFF_FFFF_FFFF_FFD8);
    send_word(REQ_ENQ, 4'd1, 64'hFFFF_FFFF_FFFF_FFE0);
    send_word(REQ_ENQ, 4'd1, 64'hFFFF_FFFF_FFFF_FFF0);
    send_word(REQ_DISP, 4'd3, 64'd70);
    // With both gates at zero any non-empty remote queue qualifies once any
    // time at all has passed.
    write_reg(REG_STEAL_MIN, 32'd0);
    write_reg(REG_STEAL_DELAY, 32'd0);
    write_reg(REG_SPARE, $urandom);
    send_word(REQ_ENQ, 4'd3, 64'd900);
    send_word(REQ_DISP, 4'd0, 64'd70);
    send_word(REQ_DISP, 4'd0, 64'd901);
    send_word(REQ_DISP, 4'd0, 64'd902);
  endtask

  // Builds one queue up to a modest depth, then checks the steal minimum at
  // its top value, equal to the depth and one below it, and refills followed
  // by local takes. The build-up runs with no gaps and no stalls.
  task automatic test_deep_queue;
    time_t t;
    set_config(16'hFFFF, 32'd0, 5'd16);
    t = 64'h0000_0100_0000_0000;
    rush = 1'b1;
    while (q_depth[9] != 16'd24) begin
      send_word(REQ_ENQ, 4'd9, t);
      t = t + 1;
    end
    rush = 1'b0;
    send_word(REQ_DISP, 4'd4, t + 10);
    write_reg(REG_STEAL_MIN, 32'd24);
    send_word(REQ_DISP, 4'd4, t + 20);
    write_reg(REG_STEAL_MIN, 32'd23);
    send_word(REQ_DISP, 4'd4, t + 25);
    send_word(REQ_ENQ, 4'd9, t + 30);
    send_word(REQ_ENQ, 4'd9, t + 40);
    send_word(REQ_DISP, 4'd9, t + 50);
    send_word(REQ_ENQ, 4'd15, t + 60);
    send_word(REQ_DISP, 4'd15, t + 70);
  endtask

  // One random phase under a fixed configuration. Most words advance the
  // time base in small steps so that the delay gate sits near its edge; a
  // few jump far ahead, land anywhere, or step back and so wrap the wait.
  // Most cluster indexes are in range; some are not.
  task automatic run_phase(input logic [MIN_W-1:0] mn, input logic [DELAY_W-1:0] dl,
                           input logic [ACT_W-1:0] act, input int words, input bit pause);
    int          lim;
    int unsigned roll;
    req_t        kind;
    logic [CLU_W-1:0] cl;
    set_config(mn, dl, act);
    lim = (act == 0) ? 1 : (act > NUM_CLUSTERS) ? NUM_CLUSTERS : int'(act);
    for (int k = 0; k < words; k++) begin
      if (pause && k == words / 2) wait_for_drain();
      kind = ($urandom_range(0, 99) < 55) ? REQ_ENQ : REQ_DISP;
      cl = ($urandom_range(0, 6) == 0) ? CLU_W'($urandom_range(0, 15))
                                       : CLU_W'($urandom_range(0, lim - 1));
      roll = $urandom_range(0, 99);
      if (roll < 80)      clock_ns = clock_ns + $urandom_range(0, 160);
      else if (roll < 90) clock_ns = clock_ns + {$urandom_range(0, 3), $urandom};
      else if (roll < 95) clock_ns = {$urandom, $urandom};
      else                clock_ns = clock_ns - $urandom_range(0, 200);
      send_word(kind, cl, clock_ns);
    end
  endtask

  // Random traffic over several settings, extremes included: both gates at
  // zero, a minimum no queue can exceed, the widest delay, and active counts
  // of zero and above the row size.
  task automatic test_random_traffic;
    run_phase(16'd0, 32'd0, 5'd16, 90, 1'b0);
    run_phase(16'd2, 32'd50, 5'd8, 90, 1'b1);
    run_phase(16'hFFFF, 32'd1000, 5'd16, 60, 1'b0);
    run_phase(16'd1, 32'hFFFF_FFFF, 5'd31, 80, 1'b0);
    run_phase(16'($urandom_range(0, 3)), $urandom_range(0, 300), 5'd0, 60, 1'b0);
    repeat (3) begin
      run_phase(16'($urandom_range(0, 4)), $urandom_range(0, 400),
                5'($urandom_range(1, 16)), 90, 1'b0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_steal_rules();
    test_deep_queue();
    test_random_traffic();
    // Let the last results come back, then give the unit time to show any
    // stray word before judging.
    wait_for_drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Guard against a hung handshake; the slowest correct run needs well
  // under a fifth of this.
  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
